FILE: design/dcq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the dual circular queue block.
package dcq_pkg;

  localparam int HALF_DEPTH_DEF = 16;
  localparam int DATA_W         = 32;
  localparam int FUNC_W         = 2;
  localparam int HS_W           = 5;
  localparam int STAT_W         = 3;
  localparam logic [HS_W-1:0] HALF_SIZE_RST = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LIST = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_LIST
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSH_OK   = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_POP_OK    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_LIST      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LIST_RD,
    BK_LIST_OUT
  } back_state_t;

  typedef struct packed {
    op_t                      op;
    logic                     sel;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

endpackage

FILE: design/dcq_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, decodes func, buffers commands in a two-entry queue.
module dcq_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dcq_pkg::FUNC_W-1:0] in_func,
  input  logic                       in_queue_sel,
  input  logic signed [dcq_pkg::DATA_W-1:0] in_value,
  output logic                       cmd_valid,
  output dcq_pkg::cmd_t              cmd,
  input  logic                       cmd_take
);
  import dcq_pkg::*;

  localparam logic [1:0] FULL = 2'd2;

  cmd_t       buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec_cmd;
  logic       dec_keep;
  logic       push_en;

  always_comb begin
    dec_cmd.sel   = in_queue_sel;
    dec_cmd.value = in_value;
    dec_cmd.op    = OP_PUSH;
    dec_keep      = 1'b1;
    unique case (in_func)
      FUNC_PUSH: dec_cmd.op = OP_PUSH;
      FUNC_POP:  dec_cmd.op = OP_POP;
      FUNC_LIST: dec_cmd.op = OP_LIST;
      default:   dec_keep = 1'b0;  // unused code: dropped, no result
    endcase
  end

  assign in_stall  = (cnt_r == FULL);
  assign push_en   = in_valid && !in_stall && dec_keep;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = buf_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (cmd_take) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push_en && !cmd_take) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push_en && cmd_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      buf_r[wr_ptr_r] <= dec_cmd;
    end
  end

  a_take_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty front queue");

endmodule

FILE: design/dcq_back.sv
`timescale 1ns / 1ps
// Back end: queue pointers, shared store, list sequencer and result register.
module dcq_back #(
  parameter int HALF_DEPTH = dcq_pkg::HALF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dcq_pkg::HS_W-1:0]   cfg_half_size,
  input  logic                       cmd_valid,
  input  dcq_pkg::cmd_t              cmd,
  output logic                       cmd_take,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dcq_pkg::STAT_W-1:0] out_status,
  output logic signed [dcq_pkg::DATA_W-1:0] out_elem,
  output logic                       out_listed_valid,
  output logic                       out_last
);
  import dcq_pkg::*;

  localparam int PW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int AW = $clog2(2 * HALF_DEPTH);
  localparam int KW = ((CW > HS_W) ? CW : HS_W) + 1;
  localparam int DEPTH = 2 * HALF_DEPTH;

  logic [HS_W-1:0]   half_size_r;
  logic [KW-1:0]     hs_k, cap_k;

  logic [PW-1:0]     head_r [2];
  logic [PW-1:0]     head_nxt [2];
  logic [PW-1:0]     tail_r [2];
  logic [PW-1:0]     tail_nxt [2];
  logic [CW-1:0]     count_r [2];
  logic [CW-1:0]     count_nxt [2];

  back_state_t       state_r, state_nxt;
  logic              list_sel_r, list_sel_nxt;
  logic [PW-1:0]     list_ptr_r, list_ptr_nxt;
  logic [CW-1:0]     list_left_r, list_left_nxt;

  logic [DATA_W-1:0] store [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [DATA_W-1:0] out_elem_r, out_elem_nxt;
  logic              out_listed_valid_r, out_listed_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_free;

  logic [PW-1:0]     sel_head, sel_tail;
  logic [CW-1:0]     sel_count;

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [KW-1:0] cap);
    logic [KW-1:0] n;
    n = KW'(p) + KW'(1);
    return (n >= cap) ? '0 : PW'(n);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic sel, input logic [PW-1:0] p);
    return sel ? (AW'(HALF_DEPTH) + AW'(p)) : AW'(p);
  endfunction

  assign cfg_ready = 1'b1;

  // capacity: zero acts as one, clamp at the half depth
  always_comb begin
    hs_k = KW'(half_size_r);
    if (hs_k == '0) begin
      cap_k = KW'(1);
    end else if (hs_k > KW'(HALF_DEPTH)) begin
      cap_k = KW'(HALF_DEPTH);
    end else begin
      cap_k = hs_k;
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign sel_head  = head_r[cmd.sel];
  assign sel_tail  = tail_r[cmd.sel];
  assign sel_count = count_r[cmd.sel];
  assign wr_addr   = addr_of(cmd.sel, sel_tail);
  assign rd_addr   = addr_of(list_sel_r, list_ptr_r);

  always_comb begin
    head_nxt             = head_r;
    tail_nxt             = tail_r;
    count_nxt            = count_r;
    state_nxt            = state_r;
    list_sel_nxt         = list_sel_r;
    list_ptr_nxt         = list_ptr_r;
    list_left_nxt        = list_left_r;
    out_valid_nxt        = out_valid_r && out_stall;
    out_status_nxt       = out_status_r;
    out_elem_nxt         = out_elem_r;
    out_listed_valid_nxt = out_listed_valid_r;
    out_last_nxt         = out_last_r;
    cmd_take             = 1'b0;
    wr_en                = 1'b0;
    rd_en                = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take             = 1'b1;
          out_valid_nxt        = 1'b1;
          out_elem_nxt         = '0;
          out_listed_valid_nxt = 1'b0;
          out_last_nxt         = 1'b1;
          unique case (cmd.op)
            OP_PUSH: begin
              if (KW'(sel_count) >= cap_k) begin
                out_status_nxt = ST_OVERFLOW;
              end else begin
                wr_en              = 1'b1;
                tail_nxt[cmd.sel]  = adv(sel_tail, cap_k);
                count_nxt[cmd.sel] = sel_count + CW'(1);
                out_status_nxt     = ST_PUSH_OK;
              end
            end
            OP_POP: begin
              if (sel_count == '0) begin
                out_status_nxt = ST_UNDERFLOW;
              end else begin
                head_nxt[cmd.sel]  = adv(sel_head, cap_k);
                count_nxt[cmd.sel] = sel_count - CW'(1);
                out_status_nxt     = ST_POP_OK;
              end
            end
            OP_LIST: begin
              out_status_nxt = ST_LIST;
              if (sel_count != '0) begin
                // no result yet; the walk emits one per entry
                out_valid_nxt = out_valid_r && out_stall;
                list_sel_nxt  = cmd.sel;
                list_ptr_nxt  = sel_head;
                list_left_nxt = sel_count;
                state_nxt     = BK_LIST_RD;
              end
            end
            default: out_valid_nxt = out_valid_r && out_stall;
          endcase
        end
      end
      BK_LIST_RD: begin
        rd_en        = 1'b1;
        list_ptr_nxt = adv(list_ptr_r, cap_k);
        state_nxt    = BK_LIST_OUT;
      end
      BK_LIST_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = ST_LIST;
          out_elem_nxt         = rd_data_r;
          out_listed_valid_nxt = 1'b1;
          out_last_nxt         = (list_left_r == CW'(1));
          list_left_nxt        = list_left_r - CW'(1);
          state_nxt            = (list_left_r == CW'(1)) ? BK_IDLE : BK_LIST_RD;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_size_r <= HALF_SIZE_RST;
      head_r      <= '{default: '0};
      tail_r      <= '{default: '0};
      count_r     <= '{default: '0};
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        half_size_r <= cfg_half_size;
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_sel_r         <= list_sel_nxt;
    list_ptr_r         <= list_ptr_nxt;
    list_left_r        <= list_left_nxt;
    out_status_r       <= out_status_nxt;
    out_elem_r         <= out_elem_nxt;
    out_listed_valid_r <= out_listed_valid_nxt;
    out_last_r         <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_elem         = out_elem_r;
  assign out_listed_valid = out_listed_valid_r;
  assign out_last         = out_last_r;

  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_LIST_RD || state_r == BK_LIST_OUT) |-> (list_left_r != '0))
    else $error("list walk running with no entries left");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CW'(HALF_DEPTH)) && (count_r[1] <= CW'(HALF_DEPTH)))
    else $error("queue count above half depth");

  a_take_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (out_free && state_r == BK_IDLE))
    else $error("command taken while result register busy or list running");

  a_listed_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_listed_valid_r) |-> (out_status_r == ST_LIST))
    else $error("listed element with non-list status");

endmodule

FILE: design/dual_circular_queue_shared_store_top.sv
`timescale 1ns / 1ps
// Two circular queues sharing one store of 2*HALF_DEPTH words. Push and pop requests
// are answered through the registered result and sustain one per cycle while the
// output is not stalled; the front holds up to two decoded requests so input and
// output can stall independently. A list request walks the queue through the store's
// registered read port: it is taken, then each listed entry is read and loaded into
// the result register; an empty queue's list ends when taken, with one result. func
// code 3 is absorbed with no result. The store has no reset or clearing pass; cfg
// writes (capacity, reset 16) are always ready and must arrive while idle.
module dual_circular_queue_shared_store_top #(
  parameter int HALF_DEPTH = dcq_pkg::HALF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [dcq_pkg::FUNC_W-1:0] in_func,
  input  logic                       in_queue_sel,
  input  logic signed [dcq_pkg::DATA_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dcq_pkg::STAT_W-1:0] out_status,
  output logic signed [dcq_pkg::DATA_W-1:0] out_elem,
  output logic                       out_listed_valid,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dcq_pkg::HS_W-1:0]   cfg_half_size
);
  import dcq_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_take;

  dcq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_queue_sel (in_queue_sel),
    .in_value     (in_value),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  dcq_back #(
    .HALF_DEPTH (HALF_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_half_size    (cfg_half_size),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_take         (cmd_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_elem         (out_elem),
    .out_listed_valid (out_listed_valid),
    .out_last         (out_last)
  );

endmodule
